FILE: hw/rtl/terminal_input_token_splitter_core_macros.svh
// Assertion helpers; expect clk and rst_n in the enclosing scope.
`ifndef TERMINAL_INPUT_TOKEN_SPLITTER_CORE_MACROS_SVH
`define TERMINAL_INPUT_TOKEN_SPLITTER_CORE_MACROS_SVH

// same-cycle implication
`define TTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tts check failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tts check failed");

`endif

FILE: hw/rtl/tts_pkg.sv
package tts_pkg;

    localparam int unsigned MAX_BUFFER_DEF = 256;

    localparam logic [1:0] ST_CONT = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [8:0] BUFFER_SIZE_RST = 9'd32;

    localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_UTF8 = 5'b00010,
        PH_ESC  = 5'b00100,
        PH_CSI  = 5'b01000,
        PH_SS   = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] utf8_rem;
        logic [7:0] len;
    } state_t;

    localparam state_t IDLE_STATE = '{phase: PH_IDLE, utf8_rem: 3'd0, len: 8'd0};

endpackage

FILE: hw/rtl/terminal_input_token_splitter_core.sv
// Terminal input token splitter.
// Input channel: byte_valid / byte_stall carry one raw terminal byte (in_byte)
// per word. Output channel: token_valid / token_stall carry one result word per
// input byte: the byte echoed, status (continue, complete, overflow) and the
// token length so far including this byte.
// Each accepted byte is held in the input register, then moved into the result
// register when it is free or token_stall is low; its result word is taken there.
// Throughput: one byte per cycle while token_stall is low; the phase / UTF-8
// count / length state that each byte reads and writes is updated as it advances.
// When token_stall holds the result register, the input register still takes
// one more byte; byte_stall rises only when both registers are full.
// Reset: both registers empty, token state idle, buffer_size = 32.
// APB register 0 (address 0): buffer_size, 9 bits; write only while idle.
`include "terminal_input_token_splitter_core_macros.svh"

module terminal_input_token_splitter_core
    import tts_pkg::*;
#(
    parameter int unsigned MAX_BUFFER = MAX_BUFFER_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    output logic        token_valid,
    input  logic        token_stall,
    output logic [7:0]  token_byte,
    output logic [1:0]  status,
    output logic [7:0]  token_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] token_byte_reg;
    logic [1:0] status_reg;
    logic [7:0] token_length_reg;
    logic [8:0] buffer_size_reg;
    state_t     state_reg;
    state_t     state_next;
    logic [1:0] status_next;
    logic [7:0] length_next;
    logic       accept_in;
    logic       advance;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BUFFER_SIZE);
    assign prdata    = (paddr[2] == REG_BUFFER_SIZE) ? {23'd0, buffer_size_reg} : 32'd0;

    assign advance    = in_valid_reg && (!out_valid_reg || !token_stall);
    assign byte_stall = in_valid_reg && out_valid_reg && token_stall;
    assign accept_in  = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!token_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    tts_step #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_step (
        .cur_byte     (in_byte_reg),
        .cur_state    (state_reg),
        .buffer_size  (buffer_size_reg),
        .next_state   (state_next),
        .status       (status_next),
        .token_length (length_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            buffer_size_reg <= BUFFER_SIZE_RST;
            state_reg       <= IDLE_STATE;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                buffer_size_reg <= pwdata[8:0];
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_byte_reg <= in_byte;
        end
        if (advance)
        begin
            token_byte_reg   <= in_byte_reg;
            status_reg       <= status_next;
            token_length_reg <= length_next;
        end
    end

    assign token_valid  = out_valid_reg;
    assign token_byte   = token_byte_reg;
    assign status       = status_reg;
    assign token_length = token_length_reg;

    `TTS_ASSERT_NEXT(a_end_goes_idle, advance && status_next != ST_CONT, state_reg == IDLE_STATE)
    `TTS_ASSERT_NOW(a_utf8_count_clear, state_reg.phase != PH_UTF8, state_reg.utf8_rem == 3'd0)
    `TTS_ASSERT_NOW(a_length_nonzero, out_valid_reg, token_length_reg != 8'd0)

endmodule

FILE: hw/rtl/tts_step.sv
module tts_step
    import tts_pkg::*;
#(
    parameter int unsigned MAX_BUFFER = MAX_BUFFER_DEF
)
(
    input  logic [7:0] cur_byte,
    input  state_t     cur_state,
    input  logic [8:0] buffer_size,
    output state_t     next_state,
    output logic [1:0] status,
    output logic [7:0] token_length
);

    localparam int unsigned SIZE_CAP = (MAX_BUFFER > 257) ? 257 : MAX_BUFFER;
    localparam logic [8:0]  SIZE_LIM = 9'(SIZE_CAP);

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SS2      = 8'h4E;
    localparam logic [7:0] CH_SS3      = 8'h4F;
    localparam logic [7:0] CH_INTER_LO = 8'h20;
    localparam logic [7:0] CH_INTER_HI = 8'h2F;
    localparam logic [7:0] CH_PARAM_LO = 8'h30;
    localparam logic [7:0] CH_PARAM_HI = 8'h3F;
    localparam logic [7:0] CH_CONT_LO  = 8'h80;
    localparam logic [7:0] CH_LEAD_LO  = 8'hC0;

    function automatic logic [2:0] utf8_extra(input logic [7:0] c);
        logic [2:0] n;
        if (c >= 8'hFC)
        begin
            n = 3'd5;
        end
        else if (c >= 8'hF8)
        begin
            n = 3'd4;
        end
        else if (c >= 8'hF0)
        begin
            n = 3'd3;
        end
        else if (c >= 8'hE0)
        begin
            n = 3'd2;
        end
        else
        begin
            n = 3'd1;
        end
        return n;
    endfunction

    logic [8:0] eff_size;
    logic [8:0] len_inc;
    logic [9:0] len_guard;
    logic       done;
    state_t     walk;

    always_comb
    begin
        eff_size  = (buffer_size < SIZE_LIM) ? buffer_size : SIZE_LIM;
        len_inc   = {1'b0, cur_state.len} + 9'd1;
        len_guard = {1'b0, len_inc} + 10'd2;
        done      = 1'b0;
        walk      = cur_state;

        case (cur_state.phase)
            PH_IDLE:
            begin
                if (cur_byte < CH_CONT_LO)
                begin
                    if (cur_byte == CH_ESC)
                    begin
                        walk.phase = PH_ESC;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else if (cur_byte >= CH_LEAD_LO)
                begin
                    walk.phase    = PH_UTF8;
                    walk.utf8_rem = utf8_extra(cur_byte);
                end
            end
            PH_UTF8:
            begin
                walk.utf8_rem = cur_state.utf8_rem - 3'd1;
                done          = (walk.utf8_rem == 3'd0);
            end
            PH_ESC:
            begin
                if (cur_byte == CH_LBRACKET)
                begin
                    walk.phase = PH_CSI;
                end
                else if (cur_byte == CH_SS2 || cur_byte == CH_SS3)
                begin
                    walk.phase = PH_SS;
                end
                else if (!(cur_byte >= CH_INTER_LO && cur_byte <= CH_INTER_HI))
                begin
                    done = 1'b1;
                end
            end
            PH_CSI:
            begin
                done = !(cur_byte >= CH_PARAM_LO && cur_byte <= CH_PARAM_HI);
            end
            PH_SS:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        if (eff_size < 9'd3)
        begin
            status       = ST_OVF;
            token_length = 8'd1;
            next_state   = IDLE_STATE;
        end
        else
        begin
            token_length = len_inc[7:0];
            if (done)
            begin
                status     = ST_DONE;
                next_state = IDLE_STATE;
            end
            else if (len_guard >= {1'b0, eff_size})
            begin
                status     = ST_OVF;
                next_state = IDLE_STATE;
            end
            else
            begin
                status     = ST_CONT;
                next_state = walk;
                next_state.len = len_inc[7:0];
            end
        end
    end

endmodule

FILE: dv/terminal_input_token_splitter_core_tb.sv
`timescale 1ns / 100ps

module terminal_input_token_splitter_core_tb;
    import tts_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SIZE_CAP = (MAX_BUFFER_DEF > 257) ? 257 : MAX_BUFFER_DEF;
    localparam logic [2:0] ADDR_BUFFER_SIZE = {REG_BUFFER_SIZE, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam logic [7:0] ESC_CHAR = 8'h1B;
    localparam logic [7:0] CSI_CHAR = 8'h5B;
    localparam logic [7:0] SS2_CHAR = 8'h4E;
    localparam logic [7:0] SS3_CHAR = 8'h4F;
    localparam int N_DIRECTED = 27;
    localparam int N_PHASES = 10;
    localparam int PHASE_WORDS = 14;

    typedef struct packed {
        logic [7:0] b;
        logic       fixed;
        logic [1:0] st;
        logic [7:0] len;
    } stim_word_t;

    typedef struct packed {
        logic [7:0] b;
        logic [1:0] st;
        logic [7:0] len;
    } token_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  in_byte = 8'd0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    logic [7:0]  token_byte;
    logic [1:0]  status;
    logic [7:0]  token_length;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    stim_word_t  stim_q [$];
    token_word_t token_q [$];
    int unsigned n_accepted = 0;
    int unsigned n_seen = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          idle_en = 1'b1;

    // predicted block state
    logic [8:0]  cfg_size = BUFFER_SIZE_RST;
    phase_t      tok_phase = PH_IDLE;
    logic [2:0]  tok_rem = 3'd0;
    logic [7:0]  tok_len = 8'd0;

    terminal_input_token_splitter_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_byte   (token_byte),
        .status       (status),
        .token_length (token_length),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    function automatic logic [2:0] utf8_tail(input logic [7:0] c);
        if (c >= 8'hFC) return 3'd5;
        if (c >= 8'hF8) return 3'd4;
        if (c >= 8'hF0) return 3'd3;
        if (c >= 8'hE0) return 3'd2;
        return 3'd1;
    endfunction

    task automatic advance_token(input logic [7:0] c, output logic [1:0] st,
                                 output logic [7:0] len);
        int eff;
        int n;
        bit done;
        eff = (int'(cfg_size) < SIZE_CAP) ? int'(cfg_size) : SIZE_CAP;
        done = 1'b0;
        if (eff < 3) begin
            st = ST_OVF;
            len = 8'd1;
        end
        else begin
            n = int'(tok_len) + 1;
            case (tok_phase)
                PH_IDLE:
                begin
                    if (c < 8'h80) begin
                        if (c == ESC_CHAR) tok_phase = PH_ESC;
                        else done = 1'b1;
                    end
                    else if (c >= 8'hC0) begin
                        tok_phase = PH_UTF8;
                        tok_rem = utf8_tail(c);
                    end
                end
                PH_UTF8:
                begin
                    tok_rem = tok_rem - 3'd1;
                    done = (tok_rem == 3'd0);
                end
                PH_ESC:
                begin
                    if (c == CSI_CHAR) tok_phase = PH_CSI;
                    else if (c == SS2_CHAR || c == SS3_CHAR) tok_phase = PH_SS;
                    else if (!(c >= 8'h20 && c <= 8'h2F)) done = 1'b1;
                end
                PH_CSI:
                begin
                    if (!(c >= 8'h30 && c <= 8'h3F)) done = 1'b1;
                end
                default: done = 1'b1;
            endcase
            len = n[7:0];
            if (done) st = ST_DONE;
            else if (n + 2 >= eff) st = ST_OVF;
            else st = ST_CONT;
        end
        if (st == ST_CONT) begin
            tok_len = len;
        end
        else begin
            tok_phase = PH_IDLE;
            tok_rem = 3'd0;
            tok_len = 8'd0;
        end
    endtask

    // byte driver and result-side stall
    always @(negedge clk) begin
        if (rst_n && (!byte_valid || n_accepted != n_seen)) begin
            n_seen = n_accepted;
            if (n_accepted < stim_q.size() && !(idle_en && $urandom_range(99) < 16)) begin
                byte_valid <= 1'b1;
                in_byte <= stim_q[n_accepted].b;
            end
            else begin
                byte_valid <= 1'b0;
            end
        end
        token_stall <= idle_en && ($urandom_range(99) < 16);
    end

    always @(posedge clk) begin : watch
        token_word_t want;
        stim_word_t item;
        logic [1:0] st;
        logic [7:0] len;
        if (rst_n) begin
            if (token_valid && !token_stall) begin
                if (token_q.size() == 0) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: unexpected word byte %02h status %0d length %0d",
                                 $time, token_byte, status, token_length);
                end
                else begin
                    want = token_q.pop_front();
                    if (token_byte !== want.b) begin
                        errors++;
                        if (errors < 50)
                            $display("%0t: token_byte expected %02h got %02h",
                                     $time, want.b, token_byte);
                    end
                    if (status !== want.st) begin
                        errors++;
                        if (errors < 50)
                            $display("%0t: status expected %0d got %0d",
                                     $time, want.st, status);
                    end
                    if (token_length !== want.len) begin
                        errors++;
                        if (errors < 50)
                            $display("%0t: token_length expected %0d got %0d",
                                     $time, want.len, token_length);
                    end
                end
            end
            if (byte_valid && !byte_stall) begin
                item = stim_q[n_accepted];
                advance_token(in_byte, st, len);
                if (item.fixed) token_q.push_back('{in_byte, item.st, item.len});
                else token_q.push_back('{in_byte, st, len});
                n_accepted++;
            end
            if (psel && penable && pready && paddr == ADDR_BUFFER_SIZE) begin
                if (pwrite) begin
                    cfg_size = pwdata[8:0];
                end
                else if (prdata !== {23'd0, cfg_size}) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: buffer_size read expected %0d got %0d",
                                 $time, cfg_size, prdata);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_buffer_size(input logic [8:0] v);
        logic [31:0] data;
        data = $urandom;
        data[8:0] = v;
        apb_access(1'b1, ADDR_BUFFER_SIZE, data);
        apb_access(1'b0, ADDR_BUFFER_SIZE, 32'd0);
    endtask

    task automatic drain();
        while (n_accepted < stim_q.size() || token_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic push_word(input logic [7:0] b);
        stim_q.push_back('{b, 1'b0, ST_CONT, 8'd0});
    endtask

    // long CSI reaches the length limit
    task automatic queue_long_csi();
        int k;
        push_word(ESC_CHAR);
        push_word(CSI_CHAR);
        k = $urandom_range(250, 270);
        repeat (k) push_word(8'($urandom_range(8'h30, 8'h3F)));
        push_word(8'($urandom_range(8'h40, 8'h7E)));
    endtask

    task automatic queue_token();
        int kind;
        int k;
        logic [7:0] c;
        kind = $urandom_range(99);
        if (kind < 20) begin
            push_word(8'($urandom_range(8'h7F)));
        end
        else if (kind < 35) begin
            push_word(ESC_CHAR);
            push_word(CSI_CHAR);
            k = $urandom_range(4);
            repeat (k) push_word(8'($urandom_range(8'h30, 8'h3F)));
            push_word(8'($urandom_range(8'h40, 8'h7E)));
        end
        else if (kind < 47) begin
            push_word(ESC_CHAR);
            k = $urandom_range(2);
            repeat (k) push_word(8'($urandom_range(8'h20, 8'h2F)));
            push_word(8'($urandom_range(8'h30, 8'h7E)));
        end
        else if (kind < 57) begin
            push_word(ESC_CHAR);
            push_word($urandom_range(1) ? SS3_CHAR : SS2_CHAR);
            push_word(8'($urandom_range(8'hFF)));
        end
        else if (kind < 77) begin
            c = 8'($urandom_range(8'hC0, 8'hFF));
            push_word(c);
            k = int'(utf8_tail(c));
            repeat (k) push_word(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 82) begin
            push_word(8'($urandom_range(8'h80, 8'hBF)));
        end
        else begin
            k = $urandom_range(1, 4);
            repeat (k) push_word(8'($urandom_range(8'hFF)));
        end
    endtask

    initial begin : main
        stim_word_t dir_tab [N_DIRECTED];
        logic [8:0] phase_sizes [N_PHASES];
        int start;
        bit paused;

        dir_tab = '{
            '{8'h00, 1'b1, ST_DONE, 8'd1},
            '{8'h7F, 1'b1, ST_DONE, 8'd1},
            '{ESC_CHAR, 1'b1, ST_CONT, 8'd1},
            '{CSI_CHAR, 1'b1, ST_CONT, 8'd2},
            '{8'h30, 1'b0, ST_CONT, 8'd0},
            '{8'h3F, 1'b0, ST_CONT, 8'd0},
            '{8'h7E, 1'b0, ST_CONT, 8'd0},
            '{ESC_CHAR, 1'b0, ST_CONT, 8'd0},
            '{SS3_CHAR, 1'b0, ST_CONT, 8'd0},
            '{8'h50, 1'b0, ST_CONT, 8'd0},
            '{ESC_CHAR, 1'b0, ST_CONT, 8'd0},
            '{SS2_CHAR, 1'b0, ST_CONT, 8'd0},
            '{8'hFF, 1'b0, ST_CONT, 8'd0},
            '{ESC_CHAR, 1'b0, ST_CONT, 8'd0},
            '{8'h2F, 1'b0, ST_CONT, 8'd0},
            '{8'h41, 1'b0, ST_CONT, 8'd0},
            '{8'hBF, 1'b1, ST_CONT, 8'd1},
            '{8'hC0, 1'b0, ST_CONT, 8'd0},
            '{8'h80, 1'b0, ST_CONT, 8'd0},
            '{8'hFC, 1'b0, ST_CONT, 8'd0},
            '{8'h80, 1'b0, ST_CONT, 8'd0},
            '{8'hBF, 1'b0, ST_CONT, 8'd0},
            '{8'h80, 1'b0, ST_CONT, 8'd0},
            '{8'hBF, 1'b0, ST_CONT, 8'd0},
            '{8'h80, 1'b0, ST_CONT, 8'd0},
            '{ESC_CHAR, 1'b1, ST_CONT, 8'd1},
            '{ESC_CHAR, 1'b1, ST_DONE, 8'd2}
        };
        phase_sizes = '{9'd32, 9'd3, 9'd256, 9'd511, 9'd0, 9'd1, 9'd2, 9'd257, 9'd4, 9'd0};
        phase_sizes[N_PHASES - 1] = 9'($urandom_range(3, 256));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset value read back, then directed words at reset buffer size
        apb_access(1'b0, ADDR_BUFFER_SIZE, 32'd0);
        foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            idle_en = 1'b1;
            set_buffer_size(phase_sizes[p]);
            if (p == 4) apb_access(1'b1, ADDR_UNUSED, $urandom);
            idle_en = (p != 2);
            start = stim_q.size();
            paused = 1'b0;
            if (p == 2) queue_long_csi();
            while (stim_q.size() < start + PHASE_WORDS) begin
                queue_token();
                if (p == 1 && !paused && stim_q.size() >= start + PHASE_WORDS / 2) begin
                    paused = 1'b1;
                    drain();
                end
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
